/* rtl/arhc_pkg.sv */
// Package for the adjacent rod hit clusterer: payload structs and fixed constants.
// No dependencies.
package arhc_pkg;

  localparam int unsigned LocW    = 9;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned CfgW    = 23;
  localparam int unsigned StatW   = 2;
  localparam int unsigned ValueW  = 24;
  localparam logic [StatW-1:0] FullFlag = 2'd2;
  localparam logic CfgIdxTime  = 1'b0;
  localparam logic CfgIdxSpace = 1'b1;

  typedef struct packed {
    logic [8:0]             rod_location;
    logic                   first_of_event;
    logic signed [ValueW-1:0] hit_time;
    logic signed [ValueW-1:0] hit_xpos;
    logic signed [ValueW-1:0] rod_geom_x;
    logic [ValueW-2:0]      energy;
    logic signed [ValueW-1:0] adc_xpos;
    logic signed [ValueW-1:0] left_amp;
    logic signed [ValueW-1:0] right_amp;
    logic [1:0]             adc_status;
  } hit_t;

  typedef struct packed {
    logic [8:0]             cluster_location;
    logic [6:0]             cluster_size;
    logic signed [ValueW-1:0] mean_time;
    logic signed [ValueW-1:0] mean_xpos;
    logic signed [ValueW-1:0] mean_adc_xpos;
    logic [ValueW-1:0]      total_energy;
    logic signed [ValueW-1:0] mean_left_amp;
    logic signed [ValueW-1:0] mean_right_amp;
    logic [1:0]             cluster_adc_status;
  } cluster_t;

endpackage

/* rtl/arhc_wmean.sv */
// Weighted mean unit: one shared multiplier and a restoring divider, one bit a cycle.
// Depends on nothing but its ports.
module arhc_wmean #(
  parameter int unsigned VW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VW-1:0] a1_i,
  input  logic [VW-1:0]        w1_i,
  input  logic signed [VW-1:0] a2_i,
  input  logic [VW-1:0]        w2_i,
  output logic                 done_o,
  output logic signed [VW-1:0] mean_o
);
  localparam int unsigned PW = 2 * VW + 1;
  localparam int unsigned DW = VW + 1;
  localparam int unsigned CW = $clog2(PW + 4);
  localparam logic [2:0] SIdle = 3'd0, SMul1 = 3'd1, SMul2 = 3'd2, SDiv = 3'd3,
                         SDone = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] m_a_q, m_a_d;
  logic [VW-1:0] m_w_q, m_w_d;
  logic [PW-1:0] p1_q, p1_d;
  logic          n1_q, n1_d, n2_q, n2_d, neg_q, neg_d;
  logic [VW-1:0] a2m_q, a2m_d, w2_q, w2_d;
  logic [DW-1:0] den_q, den_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [2*VW-1:0] prod;
  logic [PW-1:0]   p2;
  logic [DW:0]     trial;

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
    logic [VW:0] t;
    t = {a[VW-1], a};
    if (a[VW-1]) t = -t;
    return t[VW-1:0];
  endfunction

  assign prod  = m_a_q * m_w_q;
  assign p2    = {1'b0, prod};
  assign trial = {rem_q[DW-1:0], quo_q[PW-1]} - {1'b0, den_q};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; m_a_d = m_a_q; m_w_d = m_w_q; p1_d = p1_q;
    n1_d = n1_q; n2_d = n2_q; neg_d = neg_q; a2m_d = a2m_q; w2_d = w2_q;
    den_d = den_q; quo_d = quo_q; rem_d = rem_q;
    case (state_q)
      SIdle: if (start_i) begin
        m_a_d = mag(a1_i); m_w_d = w1_i; a2m_d = mag(a2_i); w2_d = w2_i;
        n1_d = a1_i[VW-1]; n2_d = a2_i[VW-1];
        den_d = {1'b0, w1_i} + {1'b0, w2_i};
        state_d = SMul1;
      end
      SMul1: begin
        p1_d = {1'b0, prod}; m_a_d = a2m_q; m_w_d = w2_q; state_d = SMul2;
      end
      SMul2: begin
        if (n1_q == n2_q) begin
          quo_d = p1_q + p2; neg_d = n1_q;
        end else if (p1_q >= p2) begin
          quo_d = p1_q - p2; neg_d = n1_q;
        end else begin
          quo_d = p2 - p1_q; neg_d = n2_q;
        end
        rem_d = '0; cnt_d = CW'(PW); state_d = SDiv;
      end
      SDiv: begin
        if (!trial[DW]) begin
          rem_d = trial; quo_d = {quo_q[PW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DW-1:0], quo_q[PW-1]}; quo_d = {quo_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_a_q <= m_a_d; m_w_q <= m_w_d; p1_q <= p1_d; n1_q <= n1_d; n2_q <= n2_d;
    neg_q <= neg_d; a2m_q <= a2m_d; w2_q <= w2_d; den_q <= den_d; quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // For a nonzero weight sum, the quotient magnitude is at most the larger input's.
  assign done_o = (state_q == SDone);
  assign mean_o = neg_q ? -quo_q[VW-1:0] : quo_q[VW-1:0];

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMul1) |-> $past(start_i)) else $error("bad start");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv) |-> (cnt_q != '0)) else $error("count underflow");
endmodule

/* rtl/adjacent_rod_hit_clusterer_core.sv */
// Top level of the adjacent rod hit clusterer: merge decision, state and sequencer.
// Depends on arhc_pkg and arhc_wmean.
//
//  channel | direction | handshake                         | payload
//  hit     | in        | hit_valid_i / hit_stall_o         | arhc_pkg::hit_t
//  cluster | out       | cluster_valid_o / cluster_stall_i | arhc_pkg::cluster_t
//  config  | in        | cfg_we_i                          | cfg_idx_i, cfg_data_i
//
// A merged item takes five passes of the shared mean unit, one per value, before
// the result is offered. A new cluster from an item that does not merge is
// offered the cycle after its item. Either way the next item waits until the
// cluster has been taken.
// Reset is asynchronous and clears the cluster state to its reset values.
// Input is stalled while an item is in work or its result waits to be taken.
module adjacent_rod_hit_clusterer_core #(
  parameter int unsigned RODS_PER_MODULE = 8,
  parameter int unsigned MAX_CLUSTER     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hit_valid_i,
  output logic                hit_stall_o,
  input  arhc_pkg::hit_t      hit_i,
  output logic                cluster_valid_o,
  input  logic                cluster_stall_i,
  output arhc_pkg::cluster_t  cluster_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [22:0]         cfg_data_i
);
  localparam int unsigned VW   = arhc_pkg::ValueW;
  localparam int unsigned Span = 8 * RODS_PER_MODULE;
  localparam logic [1:0] SIdle = 2'd0, SMean = 2'd1, SOut = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [2:0]  sel_q, sel_d;
  logic [22:0] tmax_q, smax_q;
  logic        pv_q;
  logic [8:0]  ploc_q, aloc_q;
  logic signed [VW-1:0] pt_q, px_q, pg_q;
  logic [6:0]  asize_q;
  logic signed [VW-1:0] acc_q [5];
  logic signed [VW-1:0] hv_q [5];
  logic [VW-1:0] aen_q, w1_q, w2_q;
  logic [1:0]  ast_q;
  logic        in_acc;
  logic        adjacent, merge, wm_done;
  logic signed [VW:0] td, xd0, gd0;
  logic [VW:0] tda, xa, ga, xda;
  logic signed [VW-1:0] t, x, g;
  logic [VW-1:0] e;
  logic [VW:0]   esum_full;
  logic signed [VW-1:0] wm_mean;
  logic go_q;

  assign t = VW'(hit_i.hit_time);
  assign x = VW'(hit_i.hit_xpos);
  assign g = VW'(hit_i.rod_geom_x);
  assign e = VW'(hit_i.energy);

  function automatic logic [VW:0] absv(input logic signed [VW:0] v);
    return v[VW] ? -v : v;
  endfunction

  assign adjacent = (hit_i.rod_location / Span == ploc_q / Span) &&
                    (10'(hit_i.rod_location % Span) == 10'(ploc_q % Span) + 10'd1);
  assign td  = {t[VW-1], t} - {pt_q[VW-1], pt_q};
  assign tda = absv(td);
  assign xd0 = {x[VW-1], x} - {px_q[VW-1], px_q};
  assign gd0 = {g[VW-1], g} - {pg_q[VW-1], pg_q};
  assign xa  = absv(xd0);
  assign ga  = absv(gd0);
  assign xda = (xa > ga) ? xa - ga : ga - xa;
  assign merge = pv_q && !hit_i.first_of_event && adjacent &&
                 (tda < (VW+1)'(tmax_q)) && (xda < (VW+1)'(smax_q));
  assign in_acc = hit_valid_i && !hit_stall_o;
  assign hit_stall_o = (state_q != SIdle);
  assign esum_full = {1'b0, aen_q} + {1'b0, e};

  arhc_wmean #(.VW(VW)) u_wmean (
    .clk_i, .rst_ni, .start_i(go_q), .a1_i(acc_q[sel_q]), .w1_i(w1_q),
    .a2_i(hv_q[sel_q]), .w2_i(w2_q), .done_o(wm_done), .mean_o(wm_mean));

  always_comb begin
    state_d = state_q; sel_d = sel_q;
    case (state_q)
      SIdle: if (in_acc) state_d = merge ? SMean : SOut;
      SMean: if (wm_done) begin
        sel_d = sel_q + 3'd1;
        if (sel_q == 3'd4) begin
          state_d = SOut;
          sel_d = '0;
        end
      end
      SOut: if (!cluster_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; sel_q <= '0; go_q <= 1'b0;
      tmax_q <= 23'd256; smax_q <= 23'd2560;
      pv_q <= 1'b0; ploc_q <= '0; pt_q <= '0; px_q <= '0; pg_q <= -VW'(25600);
      aloc_q <= '0; asize_q <= 7'd1; aen_q <= '0; ast_q <= '0;
      for (int i = 0; i < 5; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d; sel_q <= sel_d;
      go_q <= (state_q == SIdle && in_acc && merge) || (state_q == SMean && wm_done &&
              sel_q != 3'd4);
      if (cfg_we_i && cfg_idx_i == arhc_pkg::CfgIdxTime)  tmax_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == arhc_pkg::CfgIdxSpace) smax_q <= cfg_data_i;
      if (in_acc) begin
        pv_q <= 1'b1; ploc_q <= hit_i.rod_location; pt_q <= t; px_q <= x; pg_q <= g;
        if (merge) begin
          if (aen_q != '0 && e != '0) begin
            aen_q <= esum_full[VW] ? '1 : esum_full[VW-1:0];
          end else begin
            aen_q <= '0;
          end
          ast_q <= (ast_q == arhc_pkg::FullFlag && hit_i.adc_status == arhc_pkg::FullFlag)
                   ? arhc_pkg::FullFlag : 2'd0;
          if (asize_q < 7'(MAX_CLUSTER)) asize_q <= asize_q + 7'd1;
        end else begin
          aloc_q <= hit_i.rod_location; asize_q <= 7'd1; aen_q <= e;
          ast_q <= hit_i.adc_status;
          acc_q[0] <= t; acc_q[1] <= x; acc_q[2] <= VW'(hit_i.adc_xpos);
          acc_q[3] <= VW'(hit_i.left_amp); acc_q[4] <= VW'(hit_i.right_amp);
        end
      end
      if (state_q == SMean && wm_done) acc_q[sel_q] <= wm_mean;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hv_q[0] <= t; hv_q[1] <= x; hv_q[2] <= VW'(hit_i.adc_xpos);
      hv_q[3] <= VW'(hit_i.left_amp); hv_q[4] <= VW'(hit_i.right_amp);
      if (aen_q != '0 && e != '0) begin
        w1_q <= aen_q; w2_q <= e;
      end else begin
        w1_q <= VW'(1); w2_q <= VW'(1);
      end
    end
  end

  assign cluster_valid_o = (state_q == SOut);
  assign cluster_o = '{cluster_location: aloc_q, cluster_size: asize_q,
                       mean_time: acc_q[0], mean_xpos: acc_q[1],
                       mean_adc_xpos: acc_q[2], total_energy: aen_q,
                       mean_left_amp: acc_q[3], mean_right_amp: acc_q[4],
                       cluster_adc_status: ast_q};

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> hit_stall_o) else $error("accepted while busy");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (asize_q >= 7'd1) && (asize_q <= 7'(MAX_CLUSTER))) else $error("size range");
  a_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMean) |-> (sel_q <= 3'd4)) else $error("lane range");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cluster_valid_o && cluster_stall_i) |=> cluster_valid_o) else $error("dropped");
endmodule

/* dv/tb_adjacent_rod_hit_clusterer_core.sv */
// Self-checking testbench for adjacent_rod_hit_clusterer_core: drives rod hits and
// register writes, predicts each updated cluster and checks every output item.
// Depends on arhc_pkg and the core RTL.
module tb_adjacent_rod_hit_clusterer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SectorSpan = 64;
  localparam longint ValMax = 64'hFFFFFF;
  localparam int unsigned StallLimit = 20000;

  // Running cluster and merge predictor, plus the queue of expected clusters.
  class cluster_scoreboard;
    arhc_pkg::cluster_t pending_q[$];
    int errors;
    longint time_limit, space_limit;
    bit have_prev;
    logic [8:0] prev_loc;
    longint prev_t, prev_x, prev_g;
    logic [8:0] cl_loc;
    int cl_size;
    longint cl_t, cl_x, cl_ax, cl_e, cl_la, cl_ra;
    logic [1:0] cl_stat;

    function new();
      time_limit = 256;
      space_limit = 2560;
      have_prev = 0;
      prev_loc = '0;
      prev_t = 0;
      prev_x = 0;
      prev_g = -25600;
      cl_loc = '0;
      cl_size = 1;
      cl_t = 0; cl_x = 0; cl_ax = 0; cl_e = 0; cl_la = 0; cl_ra = 0;
      cl_stat = '0;
      errors = 0;
    endfunction

    function void set_limit(logic idx, logic [22:0] val);
      if (idx == arhc_pkg::CfgIdxTime) time_limit = val;
      else space_limit = val;
    endfunction

    static function longint abs_diff(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Energy-weighted mean with truncation toward zero.
    static function longint weighted_mean(longint a1, longint w1, longint a2, longint w2);
      longint num, q;
      num = a1 * w1 + a2 * w2;
      q = (num < 0 ? -num : num) / (w1 + w2);
      return (num < 0) ? -q : q;
    endfunction

    function void note_hit(arhc_pkg::hit_t h);
      longint t, x, g, e, w1, w2, esum;
      bit adjacent, merge;
      arhc_pkg::cluster_t c;
      t = h.hit_time; x = h.hit_xpos; g = h.rod_geom_x; e = h.energy;
      adjacent = (h.rod_location / SectorSpan == prev_loc / SectorSpan) &&
                 ((h.rod_location % SectorSpan) == (prev_loc % SectorSpan) + 1);
      merge = have_prev && !h.first_of_event && adjacent &&
              abs_diff(t, prev_t) < time_limit &&
              abs_diff(abs_diff(x, prev_x), abs_diff(g, prev_g)) < space_limit;
      if (merge) begin
        w1 = 1; w2 = 1; esum = 0;
        if (cl_e != 0 && e != 0) begin
          w1 = cl_e; w2 = e;
          esum = cl_e + e;
          if (esum > ValMax) esum = ValMax;
        end
        cl_t  = weighted_mean(cl_t, w1, t, w2);
        cl_x  = weighted_mean(cl_x, w1, x, w2);
        cl_ax = weighted_mean(cl_ax, w1, h.adc_xpos, w2);
        cl_la = weighted_mean(cl_la, w1, h.left_amp, w2);
        cl_ra = weighted_mean(cl_ra, w1, h.right_amp, w2);
        cl_e = esum;
        cl_stat = (cl_stat == arhc_pkg::FullFlag && h.adc_status == arhc_pkg::FullFlag)
                  ? arhc_pkg::FullFlag : 2'd0;
        if (cl_size < 64) cl_size++;
      end else begin
        cl_loc = h.rod_location; cl_size = 1;
        cl_t = t; cl_x = x; cl_ax = h.adc_xpos; cl_e = e;
        cl_la = h.left_amp; cl_ra = h.right_amp; cl_stat = h.adc_status;
      end
      have_prev = 1;
      prev_loc = h.rod_location; prev_t = t; prev_x = x; prev_g = g;
      c.cluster_location = cl_loc;
      c.cluster_size = cl_size[6:0];
      c.mean_time = cl_t[23:0];
      c.mean_xpos = cl_x[23:0];
      c.mean_adc_xpos = cl_ax[23:0];
      c.total_energy = cl_e[23:0];
      c.mean_left_amp = cl_la[23:0];
      c.mean_right_amp = cl_ra[23:0];
      c.cluster_adc_status = cl_stat;
      pending_q.push_back(c);
    endfunction

    function void check_cluster(arhc_pkg::cluster_t got);
      arhc_pkg::cluster_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected cluster item %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.cluster_location !== want.cluster_location)
        report("cluster_location", want.cluster_location, got.cluster_location);
      if (got.cluster_size !== want.cluster_size)
        report("cluster_size", want.cluster_size, got.cluster_size);
      if (got.mean_time !== want.mean_time)
        report("mean_time", want.mean_time, got.mean_time);
      if (got.mean_xpos !== want.mean_xpos)
        report("mean_xpos", want.mean_xpos, got.mean_xpos);
      if (got.mean_adc_xpos !== want.mean_adc_xpos)
        report("mean_adc_xpos", want.mean_adc_xpos, got.mean_adc_xpos);
      if (got.total_energy !== want.total_energy)
        report("total_energy", want.total_energy, got.total_energy);
      if (got.mean_left_amp !== want.mean_left_amp)
        report("mean_left_amp", want.mean_left_amp, got.mean_left_amp);
      if (got.mean_right_amp !== want.mean_right_amp)
        report("mean_right_amp", want.mean_right_amp, got.mean_right_amp);
      if (got.cluster_adc_status !== want.cluster_adc_status)
        report("cluster_adc_status", want.cluster_adc_status, got.cluster_adc_status);
    endfunction

    function void report(string name, logic [23:0] want, logic [23:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hit_valid_i = 1'b0;
  logic hit_stall_o;
  arhc_pkg::hit_t hit_i = '0;
  logic cluster_valid_o;
  logic cluster_stall_i = 1'b1;
  arhc_pkg::cluster_t cluster_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [22:0] cfg_data_i = '0;

  cluster_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;

  adjacent_rod_hit_clusterer_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Checker and stall watchdog sample at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cluster_valid_o && !cluster_stall_i) sb.check_cluster(cluster_o);
      if ((hit_valid_i && !hit_stall_o) || (cluster_valid_o && !cluster_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("%0t: timeout, %0d clusters outstanding", $time, sb.pending_q.size());
        $display("** adjacent_rod_hit_clusterer_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random stall per item, plus one long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        cluster_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        cluster_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      cluster_stall_i <= 1'b0;
      do @(posedge clk_i); while (!cluster_valid_o);
    end
  end

  // Withdraws the offered item and waits until every expected cluster is out.
  task automatic wait_drained();
    @(negedge clk_i);
    hit_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [22:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(idx, val);
  endtask

  task automatic send_hit(arhc_pkg::hit_t h, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i);
      hit_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    hit_valid_i <= 1'b1;
    hit_i <= h;
    do @(posedge clk_i); while (hit_stall_o);
    sb.note_hit(h);
  endtask

  function automatic arhc_pkg::hit_t random_hit();
    arhc_pkg::hit_t h;
    h = arhc_pkg::hit_t'($bits(arhc_pkg::hit_t)'({$urandom, $urandom, $urandom,
        $urandom, $urandom, $urandom, $urandom}));
    h.rod_location = 9'($urandom_range(0, 511));
    return h;
  endfunction

  // Next-rod hit, merging with the previous one under wide limits in a sector.
  function automatic arhc_pkg::hit_t next_rod(arhc_pkg::hit_t p);
    arhc_pkg::hit_t h;
    h = random_hit();
    h.first_of_event = 1'b0;
    h.rod_location = p.rod_location + 9'd1;
    h.hit_time = 24'(p.hit_time + $signed($urandom_range(0, 200)) - 100);
    h.hit_xpos = 24'(p.hit_xpos + $signed($urandom_range(0, 4000)) - 2000);
    h.rod_geom_x = 24'(p.rod_geom_x + h.hit_xpos - p.hit_xpos
                   + $signed($urandom_range(0, 2000)) - 1000);
    case ($urandom_range(0, 3))
      0: h.energy = '0;
      1: h.energy = 23'($urandom_range(1, 4000));
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) h.adc_status = arhc_pkg::FullFlag;
    return h;
  endfunction

  task automatic run_chains(int n_items);
    arhc_pkg::hit_t h;
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      h = random_hit();
      h.first_of_event = 1'($urandom_range(0, 1));
      h.rod_location = 9'($urandom_range(0, 383));
      h.hit_time = 24'($signed($urandom_range(0, 20000)) - 10000);
      h.hit_xpos = 24'($signed($urandom_range(0, 20000)) - 10000);
      h.rod_geom_x = 24'($signed($urandom_range(0, 20000)) - 10000);
      if ($urandom_range(0, 4) == 0) h = random_hit();
      send_hit(h);
      sent++;
      len = $urandom_range(0, 6);
      for (int k = 0; k < len && sent < n_items; k++) begin
        h = ($urandom_range(0, 9) == 0) ? random_hit() : next_rod(h);
        send_hit(h);
        sent++;
      end
    end
  endtask

  initial begin
    arhc_pkg::hit_t h;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes of the fields and the named corner cases.
    h = '0;
    h.first_of_event = 1'b0;
    h.rod_location = 9'd1; // first hit after reset never merges
    send_hit(h);
    h.rod_location = 9'd2; send_hit(h);
    h = '1; h.rod_location = 9'd3; h.first_of_event = 1'b0; send_hit(h);
    h = '0; h.hit_time = 24'sh800000; h.hit_xpos = 24'sh800000;
    h.adc_xpos = 24'sh7FFFFF; h.left_amp = 24'sh800000; h.right_amp = 24'sh7FFFFF;
    h.energy = 23'h7FFFFF; h.rod_location = 9'd10; h.adc_status = arhc_pkg::FullFlag;
    send_hit(h);
    h.rod_location = 9'd11; h.adc_xpos = 24'sh800000; h.left_amp = 24'sh7FFFFF;
    send_hit(h); // largest energy sum on merge, just below the saturation value
    h.rod_location = 9'd12; h.adc_status = 2'd3; h.energy = '0; send_hit(h);
    h.rod_location = 9'd13; h.first_of_event = 1'b1; send_hit(h);
    // End of sector: 63 then 64 must not merge.
    h = '0; h.rod_location = 9'd63; h.energy = 23'd100; send_hit(h);
    h.rod_location = 9'd64; send_hit(h);
    // Locations beyond 383.
    h.rod_location = 9'd510; send_hit(h);
    h.rod_location = 9'd511; send_hit(h);
    write_reg(arhc_pkg::CfgIdxTime, 23'h7FFFFF);
    write_reg(arhc_pkg::CfgIdxSpace, 23'h7FFFFF);
    h = '0; h.rod_location = 9'd0; h.first_of_event = 1'b1; send_hit(h, 1);
    for (int i = 1; i < 64; i++) begin
      h = next_rod(h);
      send_hit(h, 1);
    end
    h.rod_location = 9'd448; h.first_of_event = 1'b1; send_hit(h);
    for (int i = 0; i < 66; i++) begin
      // Same data along a full beyond-range sector, so the size reaches its cap.
      h.first_of_event = 1'b0;
      h.rod_location = (h.rod_location == 9'd511) ? 9'd448 : h.rod_location + 9'd1;
      if (h.rod_location == 9'd448) h.first_of_event = 1'b1;
      send_hit(h, 1);
    end
    wait_drained();

    // Receiver hold-off while the sender keeps offering items.
    hold_off = 1;
    run_chains(20);
    wait_drained();

    write_reg(arhc_pkg::CfgIdxTime, 23'd0);
    write_reg(arhc_pkg::CfgIdxSpace, 23'd0);
    run_chains(40);
    write_reg(arhc_pkg::CfgIdxTime, 23'd256);
    write_reg(arhc_pkg::CfgIdxSpace, 23'd2560);
    run_chains(100);
    write_reg(arhc_pkg::CfgIdxTime, 23'd60);
    write_reg(arhc_pkg::CfgIdxSpace, 23'd800);
    run_chains(150);
    write_reg(arhc_pkg::CfgIdxTime, 23'h7FFFFF);
    write_reg(arhc_pkg::CfgIdxSpace, 23'h7FFFFF);
    run_chains(150);
    wait_drained();
    repeat (600) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("** adjacent_rod_hit_clusterer_core: PASSED **");
    else
      $display("** adjacent_rod_hit_clusterer_core: FAILED **");
    $finish;
  end
endmodule

/* filelist.f */
rtl/arhc_pkg.sv
rtl/arhc_wmean.sv
rtl/adjacent_rod_hit_clusterer_core.sv
dv/tb_adjacent_rod_hit_clusterer_core.sv
